@@ rtl/core/c2p_pkg.sv @@
// Package for the cartesian-to-polar converter: widths, angle constants,
// the arctangent table and the per-item flag struct.
// No dependencies.
package c2p_pkg;

  // Guard bits shifted under the coordinates in the CORDIC datapath
  localparam int GuardBits = 16;

  // Angle accumulator, degrees with 16 fractional bits (signed)
  localparam int ZW     = 25;
  // Arctangent table entry width
  localparam int AtanW  = 22;
  // First-quadrant angle, 0..90 degrees in Q16
  localparam int TW     = 23;
  // Full-circle angle sum, 0..360 degrees in Q16 plus rounding bias
  localparam int TotW   = 25;
  // Output widths
  localparam int MagW   = 16;
  localparam int AngW   = 17;

  localparam logic [TW-1:0]   Deg45Q16   = 23'd2949120;
  localparam logic [TW-1:0]   Deg90Q16   = 23'd5898240;
  localparam logic [TotW-1:0] Deg180Q16  = 25'd11796480;
  localparam logic [TotW-1:0] Deg360Q16  = 25'd23592960;
  localparam logic [TotW-1:0] RoundBias  = 25'd128;
  localparam logic [AngW-1:0] AngFull    = 17'd92160;
  localparam logic [32:0]     MagMax     = 33'd65535;

  // atan(2^-i) in degrees, Q16, rounded to nearest
  localparam logic [AtanW-1:0] AtanLut [32] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,
    22'd57,      22'd29,      22'd14,     22'd7,
    22'd4,       22'd2,       22'd1,      22'd0,
    22'd0,       22'd0,       22'd0,      22'd0,
    22'd0,       22'd0,       22'd0,      22'd0
  };

  // Quadrant signs and exact-angle cases that ride along with each point
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic y_zero;   // point on the x axis (or origin): angle 0
    logic x_zero;   // point on the y axis: angle 90
    logic diag;     // |x| == |y|: angle 45
  } flags_t;

endpackage

@@ rtl/core/cartesian_to_polar_degrees.sv @@
// Cartesian-to-polar converter: pipelined CORDIC (angle) beside a pipelined
// restoring square root (magnitude). Depends on c2p_pkg.
//
// Usage: a point is taken on every clock where start_i is high. busy_o is
// never asserted, so one point per cycle is accepted indefinitely. Each
// result is on magnitude_o and angle_deg_o for a single cycle, flagged by
// done_o. Results leave in acceptance order. Five register stages (s0, s1,
// the load of entry [0], f1 and f2) sit around the stage chain of the CORDIC
// (one rotation per stage), which runs in step with the square root (one
// root bit per stage). The receiver cannot stall the block, so done_o must
// be sampled when it pulses. angle_deg_o is degrees in 0..<360 with 8
// fractional bits.
module cartesian_to_polar_degrees #(
  parameter int COORD_BITS = 16,
  parameter int ITERATIONS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  output logic                         done_o,
  output logic [15:0]                  magnitude_o,
  output logic [16:0]                  angle_deg_o
);
  import c2p_pkg::*;

  localparam int Depth   = (ITERATIONS > COORD_BITS) ? ITERATIONS : COORD_BITS;
  localparam int Latency = Depth + 5;
  localparam int W       = COORD_BITS + GuardBits + 2;  // CORDIC x/y width
  localparam int SqW     = 2 * COORD_BITS;              // sum of squares width

  // Never stalls
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------
  // Stage s0: absolute values and signs
  // ---------------------------------------------------------------------
  logic                  v0_q;
  logic [COORD_BITS-1:0] ax0_q, ay0_q;
  logic                  nx0_q, ny0_q;
  logic [COORD_BITS-1:0] ax0_d, ay0_d;

  // Two's complement negate; the most negative value maps onto 2^(N-1)
  assign ax0_d = coord_x_i[COORD_BITS-1] ? COORD_BITS'(-coord_x_i) : COORD_BITS'(coord_x_i);
  assign ay0_d = coord_y_i[COORD_BITS-1] ? COORD_BITS'(-coord_y_i) : COORD_BITS'(coord_y_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    ax0_q <= ax0_d;
    ay0_q <= ay0_d;
    nx0_q <= coord_x_i[COORD_BITS-1];
    ny0_q <= coord_y_i[COORD_BITS-1];
  end

  // ---------------------------------------------------------------------
  // Stage s1: squares and special-case flags
  // ---------------------------------------------------------------------
  logic                  v1_q;
  logic [COORD_BITS-1:0] ax1_q, ay1_q;
  logic [SqW-1:0]        sqx1_q, sqy1_q;
  flags_t                flg1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax1_q         <= ax0_q;
    ay1_q         <= ay0_q;
    sqx1_q        <= SqW'(ax0_q) * SqW'(ax0_q);
    sqy1_q        <= SqW'(ay0_q) * SqW'(ay0_q);
    flg1_q.neg_x  <= nx0_q;
    flg1_q.neg_y  <= ny0_q;
    flg1_q.y_zero <= (ay0_q == '0);
    flg1_q.x_zero <= (ax0_q == '0);
    flg1_q.diag   <= (ax0_q == ay0_q);
  end

  // ---------------------------------------------------------------------
  // Iteration pipeline: entry [0] is loaded from s1, stage k fills [k+1]
  // ---------------------------------------------------------------------
  logic                  pv_q    [Depth+1];
  logic signed [W-1:0]   px_q    [Depth+1];
  logic signed [W-1:0]   py_q    [Depth+1];
  logic signed [ZW-1:0]  pz_q    [Depth+1];
  logic [SqW-1:0]        prem_q  [Depth+1];
  logic [SqW-1:0]        proot_q [Depth+1];
  flags_t                pflg_q  [Depth+1];

  // Load: guard-shifted coordinates, sum of squares as the initial remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q[0] <= 1'b0;
    end else begin
      pv_q[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q[0]    <= $signed(W'({ax1_q, {GuardBits{1'b0}}}));
    py_q[0]    <= $signed(W'({ay1_q, {GuardBits{1'b0}}}));
    pz_q[0]    <= '0;
    prem_q[0]  <= sqx1_q + sqy1_q;
    proot_q[0] <= '0;
    pflg_q[0]  <= flg1_q;
  end

  for (genvar k = 0; k < Depth; k++) begin : g_stage
    logic signed [W-1:0]  x_d, y_d;
    logic signed [ZW-1:0] z_d;
    logic [SqW-1:0]       rem_d, root_d;

    // CORDIC vectoring rotation k, or pass-through past the last iteration
    if (k < ITERATIONS) begin : g_rot
      localparam logic signed [ZW-1:0] AtanK = $signed(ZW'(AtanLut[k]));
      logic signed [W-1:0] dx, dy;

      assign dx = py_q[k] >>> k;
      assign dy = px_q[k] >>> k;

      always_comb begin
        if (py_q[k] > 0) begin
          x_d = px_q[k] + dx;
          y_d = py_q[k] - dy;
          z_d = pz_q[k] + AtanK;
        end else begin
          x_d = px_q[k] - dx;
          y_d = py_q[k] + dy;
          z_d = pz_q[k] - AtanK;
        end
      end
    end else begin : g_rot_pass
      assign x_d = px_q[k];
      assign y_d = py_q[k];
      assign z_d = pz_q[k];
    end

    // Square root: settle one root bit, or pass-through once all are done
    if (k < COORD_BITS) begin : g_root
      localparam logic [SqW:0] BitK = (SqW + 1)'(1) << (2 * (COORD_BITS - 1 - k));
      logic [SqW:0] trial;

      assign trial = {1'b0, proot_q[k]} + BitK;

      always_comb begin
        if ({1'b0, prem_q[k]} >= trial) begin
          rem_d  = prem_q[k] - trial[SqW-1:0];
          root_d = (proot_q[k] >> 1) + BitK[SqW-1:0];
        end else begin
          rem_d  = prem_q[k];
          root_d = proot_q[k] >> 1;
        end
      end
    end else begin : g_root_pass
      assign rem_d  = prem_q[k];
      assign root_d = proot_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pv_q[k+1] <= 1'b0;
      end else begin
        pv_q[k+1] <= pv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      px_q[k+1]    <= x_d;
      py_q[k+1]    <= y_d;
      pz_q[k+1]    <= z_d;
      prem_q[k+1]  <= rem_d;
      proot_q[k+1] <= root_d;
      pflg_q[k+1]  <= pflg_q[k];
    end
  end

  // ---------------------------------------------------------------------
  // Stage f1: clamp, exact cases, quadrant placement, magnitude rounding
  // ---------------------------------------------------------------------
  logic                  vf1_q;
  logic [TotW-1:0]       total_q;
  logic [COORD_BITS:0]   mag_q;

  logic signed [ZW-1:0]  z_fin;
  flags_t                flg_fin;
  logic [TW-1:0]         t_clamp, t_sel;
  logic [TotW-1:0]       total_d;
  logic [COORD_BITS-1:0] root_fin;
  logic [COORD_BITS:0]   mag_d;

  assign z_fin    = pz_q[Depth];
  assign flg_fin  = pflg_q[Depth];
  assign root_fin = proot_q[Depth][COORD_BITS-1:0];

  // First-quadrant angle clamped to [0, 90]
  always_comb begin
    if (z_fin < 0) begin
      t_clamp = '0;
    end else if (z_fin > $signed(ZW'(Deg90Q16))) begin
      t_clamp = Deg90Q16;
    end else begin
      t_clamp = z_fin[TW-1:0];
    end
  end

  // Axis and diagonal points take exact angles; x-axis test wins
  always_comb begin
    priority if (flg_fin.y_zero) begin
      t_sel = '0;
    end else if (flg_fin.x_zero) begin
      t_sel = Deg90Q16;
    end else if (flg_fin.diag) begin
      t_sel = Deg45Q16;
    end else begin
      t_sel = t_clamp;
    end
  end

  // Place into the quadrant given by the signs
  always_comb begin
    unique case ({flg_fin.neg_x, flg_fin.neg_y})
      2'b00:   total_d = TotW'(t_sel);
      2'b10:   total_d = Deg180Q16 - TotW'(t_sel);
      2'b11:   total_d = Deg180Q16 + TotW'(t_sel);
      default: total_d = Deg360Q16 - TotW'(t_sel);
    endcase
  end

  // Round to nearest: bump when the remainder exceeds the floor root
  assign mag_d = {1'b0, root_fin} +
                 (COORD_BITS + 1)'(prem_q[Depth] > proot_q[Depth]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf1_q <= 1'b0;
    end else begin
      vf1_q <= pv_q[Depth];
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
    mag_q   <= mag_d;
  end

  // ---------------------------------------------------------------------
  // Stage f2: round angle to Q8, wrap 360 to 0, saturate magnitude
  // ---------------------------------------------------------------------
  logic [TotW-1:0] ang_sum;
  logic [AngW-1:0] ang_q8, ang_d;
  logic [32:0]     mag_ext;
  logic [MagW-1:0] mag_sat;

  assign ang_sum = total_q + RoundBias;
  assign ang_q8  = ang_sum[TotW-1:8];
  assign ang_d   = (ang_q8 >= AngFull) ? (ang_q8 - AngFull) : ang_q8;

  assign mag_ext = 33'(mag_q);
  assign mag_sat = (mag_ext > MagMax) ? MagMax[MagW-1:0] : mag_ext[MagW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= vf1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    magnitude_o <= mag_sat;
    angle_deg_o <= ang_d;
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Every result traces back to an earlier transaction on start_i
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Latency))
    else $error("result without a matching transaction");

  // Valid bit crosses the iteration chain from entry [0] to entry [Depth]
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q[Depth] |-> $past(pv_q[0], Depth))
    else $error("iteration pipeline valid slipped");

  // Angle always wrapped below a full turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (angle_deg_o < AngFull))
    else $error("angle not wrapped below 360 degrees");

  // Zero magnitude only at the origin, which has angle 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (magnitude_o == '0)) |-> (angle_deg_o == '0))
    else $error("origin gave a nonzero angle");

endmodule

@@ dv/polar_ledger_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the cartesian-to-polar converter: its own model of the rounded
// magnitude and the CORDIC angle in degrees, plus the queue of results in flight.
// Depends on c2p_pkg for the result widths.
package polar_ledger_pkg;
  import c2p_pkg::MagW;
  import c2p_pkg::AngW;

  localparam int     CoordW      = 16;
  localparam int     CordicSteps = 16;
  localparam longint DegQ16      = 65536;   // one degree, 16 fraction bits
  localparam longint FullTurnQ8  = 92160;   // 360 degrees, 8 fraction bits
  localparam longint MagLimit    = 65535;
  localparam int     ReportMax   = 10;

  // atan(2^-k) in degrees, Q16, rounded to nearest
  localparam longint AtanDegQ16 [32] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic [MagW-1:0] mag;
    logic [AngW-1:0] ang;
  } polar_t;

  class polar_ledger;
    polar_t      due_q[$];
    int unsigned faults;

    function int unsigned failures();
      return faults;
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    // Count a failure; only the first few get printed
    function void fault(string msg);
      faults++;
      if (faults <= ReportMax) begin
        $display("%0t: %s", $realtime, msg);
      end
    endfunction

    // Expected magnitude and angle of one point
    static function polar_t polar_of_point(logic signed [CoordW-1:0] px,
                                           logic signed [CoordW-1:0] py);
      longint sx, sy, ax, ay, sq, root, trial;
      longint vx, vy, dvx, dvy, zacc, quad, tot, ang;
      polar_t res;
      sx = px;
      sy = py;
      ax = (sx < 0) ? -sx : sx;
      ay = (sy < 0) ? -sy : sy;

      // integer square root, then round to nearest
      sq = ax * ax + ay * ay;
      root = 0;
      for (int b = 16; b >= 0; b--) begin
        trial = root | (longint'(1) <<< b);
        if (trial * trial <= sq) root = trial;
      end
      if (sq - root * root > root) root++;
      if (root > MagLimit) root = MagLimit;

      // first-quadrant angle: exact on the axes and the diagonal
      if (ay == 0) begin
        quad = 0;
      end else if (ax == 0) begin
        quad = 90 * DegQ16;
      end else if (ax == ay) begin
        quad = 45 * DegQ16;
      end else begin
        vx = ax <<< 16;
        vy = ay <<< 16;
        zacc = 0;
        for (int k = 0; k < CordicSteps && k < 32; k++) begin
          dvx = vy >>> k;
          dvy = vx >>> k;
          if (vy > 0) begin
            vx += dvx;
            vy -= dvy;
            zacc += AtanDegQ16[k];
          end else begin
            vx -= dvx;
            vy += dvy;
            zacc -= AtanDegQ16[k];
          end
        end
        if (zacc < 0) zacc = 0;
        if (zacc > 90 * DegQ16) zacc = 90 * DegQ16;
        quad = zacc;
      end

      // place in quadrant, round half up to Q8, wrap 360 to 0
      if (sx >= 0 && sy >= 0) tot = quad;
      else if (sx < 0 && sy >= 0) tot = 180 * DegQ16 - quad;
      else if (sx < 0) tot = 180 * DegQ16 + quad;
      else tot = 360 * DegQ16 - quad;
      ang = (tot + 128) >>> 8;
      if (ang >= FullTurnQ8) ang -= FullTurnQ8;

      res.mag = root[MagW-1:0];
      res.ang = ang[AngW-1:0];
      return res;
    endfunction

    // Accepted point: queue its expected result
    function void note_point(logic signed [CoordW-1:0] px,
                             logic signed [CoordW-1:0] py);
      due_q.push_back(polar_of_point(px, py));
    endfunction

    // Strobed result: compare against the oldest expectation
    function void check_polar(logic [MagW-1:0] mag, logic [AngW-1:0] ang);
      polar_t want;
      if (due_q.size() == 0) begin
        fault($sformatf("unexpected result mag=%0d ang=%0d", mag, ang));
        return;
      end
      want = due_q.pop_front();
      if (mag !== want.mag) begin
        fault($sformatf("magnitude mismatch: expected %0d, got %0d", want.mag, mag));
      end
      if (ang !== want.ang) begin
        fault($sformatf("angle mismatch: expected %0d, got %0d", want.ang, ang));
      end
    endfunction

    // End of run: anything still queued never came out
    function void close_out();
      if (due_q.size() != 0) begin
        fault($sformatf("%0d expected results never arrived", due_q.size()));
      end
    endfunction
  endclass

endpackage

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Top-level testbench for cartesian_to_polar_degrees: directed and random points,
// random start gaps, results checked against the scoreboard model.
// Depends on polar_ledger_pkg and the RTL (c2p_pkg, cartesian_to_polar_degrees).
module tb_top;
  import polar_ledger_pkg::*;

  localparam int RandPoints  = 700;
  localparam int SteadyTail  = 150;   // last stretch runs without gaps
  localparam int SettleCyc   = 60;    // > pipeline latency
  localparam int DrainLimit  = 5000;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     start_i     = 1'b0;
  logic signed [CoordW-1:0] coord_x_i   = '0;
  logic signed [CoordW-1:0] coord_y_i   = '0;
  logic                     busy_o;
  logic                     done_o;
  logic [15:0]              magnitude_o;
  logic [16:0]              angle_deg_o;

  polar_ledger ledger;

  cartesian_to_polar_degrees #(
    .COORD_BITS (CoordW),
    .ITERATIONS (CordicSteps)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .coord_x_i   (coord_x_i),
    .coord_y_i   (coord_y_i),
    .done_o      (done_o),
    .magnitude_o (magnitude_o),
    .angle_deg_o (angle_deg_o)
  );

  // 100 MHz clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Result monitor: a result lives for exactly one cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      ledger.check_polar(magnitude_o, angle_deg_o);
    end
  end

  // Present one point and hold it until the transaction is taken
  task automatic send_point(input logic signed [CoordW-1:0] px,
                            input logic signed [CoordW-1:0] py);
    start_i   <= 1'b1;
    coord_x_i <= px;
    coord_y_i <= py;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    ledger.note_point(px, py);
  endtask

  // Sender gap with start_i low, junk on the coordinate ports
  task automatic idle_burst();
    start_i   <= 1'b0;
    coord_x_i <= CoordW'($urandom);
    coord_y_i <= CoordW'($urandom);
    repeat ($urandom_range(1, 13)) @(posedge clk_i);
  endtask

  // Hold off until every queued result is back (bounded)
  task automatic drain();
    int guard;
    guard = 0;
    start_i <= 1'b0;
    @(posedge clk_i);
    while (ledger.pending() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  // Random point: full range most often, plus small, axis, diagonal and corner values
  task automatic pick_point(output logic signed [CoordW-1:0] px,
                            output logic signed [CoordW-1:0] py);
    logic signed [CoordW-1:0] corner [7];
    logic signed [CoordW-1:0] a;
    int                       d;
    corner = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32766, 16'sd32767};
    a = CoordW'($urandom);
    d = int'($urandom_range(0, 4)) - 2;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        px = CoordW'($urandom);
        py = CoordW'($urandom);
      end
      4, 5: begin
        px = CoordW'(int'($urandom_range(0, 63)) - 32);
        py = CoordW'(int'($urandom_range(0, 63)) - 32);
      end
      6: begin
        px = $urandom_range(0, 1) ? a : '0;
        py = (px == 0) ? a : '0;
      end
      7: begin
        px = a;
        py = ($urandom_range(0, 1) ? a : -a) + CoordW'(d);
      end
      8: begin
        px = corner[$urandom_range(0, 6)];
        py = corner[$urandom_range(0, 6)];
      end
      default: begin
        px = CoordW'($urandom);
        py = corner[$urandom_range(0, 6)] + CoordW'(d);
      end
    endcase
  endtask

  // Main sequence
  initial begin
    logic signed [CoordW-1:0] dir_x [24];
    logic signed [CoordW-1:0] dir_y [24];
    logic signed [CoordW-1:0] px, py;
    int                       guard;

    // origin, both axes both ways, corners, diagonals, each quadrant
    dir_x = '{0, 1, 0, -1, 0, 32767, -32768, 0, 0, 32767, -32768, -32768,
              32767, 5, -7, -9, 11, 3, -4, -3, 4, 1, 32767, -32768};
    dir_y = '{0, 0, 1, 0, -1, 0, 0, 32767, -32768, 32767, -32768, 32767,
              -32768, 5, 7, -9, -11, 4, 3, -4, -3, 32767, -1, -1};

    ledger = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed points
    foreach (dir_x[k]) begin
      send_point(dir_x[k], dir_y[k]);
      if ($urandom_range(0, 2) == 0) idle_burst();
    end
    drain();

    // Random points, with one full pause in the middle
    for (int n = 0; n < RandPoints; n++) begin
      pick_point(px, py);
      send_point(px, py);
      if (n == RandPoints / 2) begin
        drain();
      end else if (n < RandPoints - SteadyTail && $urandom_range(0, 3) == 0) begin
        idle_burst();
      end
    end
    start_i <= 1'b0;

    // Wait out the pipeline, then a margin for stray strobes
    guard = 0;
    while (ledger.pending() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SettleCyc) @(posedge clk_i);
    ledger.close_out();

    if (ledger.failures() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ cartesian_to_polar_degrees.f @@
rtl/core/c2p_pkg.sv
rtl/core/cartesian_to_polar_degrees.sv
dv/polar_ledger_pkg.sv
dv/tb_top.sv
